// ===== rtl/swing_peer_bitmap_macros.svh =====
// Assertion macros for the swing_peer_bitmap checker.
// Depends on nothing; included by swp_checker.sv.
`ifndef SWING_PEER_BITMAP_MACROS_SVH
`define SWING_PEER_BITMAP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swing_peer_bitmap: implication check failed");

// Next-cycle implication, disabled during reset.
`define SWP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swing_peer_bitmap: next-cycle check failed");

`endif

// ===== rtl/swp_pkg.sv =====
// Types, constants and peer-map functions for swing_peer_bitmap.
// No dependencies; used by every other file but the macros header.
package swp_pkg;

   localparam int RANKS    = 64;
   localparam int RANK_W   = $clog2(RANKS);
   localparam int STEP_W   = 3;
   localparam int STEP_MAX = RANK_W;   // largest usable step count

   typedef logic [RANK_W-1:0] rank_type;
   typedef logic [STEP_W-1:0] step_type;
   typedef logic [RANKS-1:0]  bitmap_type;

   localparam step_type STEP_COUNT_RESET = step_type'(2);

   // rho(s) = (1 - (-2)^(s+1)) / 3, low bits only (all math is mod 2^RANK_W)
   function automatic rank_type rho_f(input step_type s);
      rank_type r;
      case (s)
         3'd0:    r = rank_type'(1);
         3'd1:    r = rank_type'(-1);
         3'd2:    r = rank_type'(3);
         3'd3:    r = rank_type'(-5);
         3'd4:    r = rank_type'(11);
         3'd5:    r = rank_type'(-21);
         3'd6:    r = rank_type'(43);
         default: r = rank_type'(-85);   // step 7
      endcase
      return r;
   endfunction

   // Effective step count: saturate to log2 of the rank count.
   function automatic step_type eff_steps_f(input step_type sc);
      return (sc > step_type'(STEP_MAX)) ? step_type'(STEP_MAX) : sc;
   endfunction

   // mask = p - 1, p = 2^n
   function automatic rank_type mask_f(input step_type n);
      return rank_type'(~(rank_type'('1) << n));
   endfunction

   // Peer: even ranks add rho, odd ranks subtract it.
   function automatic rank_type peer_f(input rank_type r, input step_type s,
                                       input rank_type mask);
      rank_type v;
      v = r[0] ? (r - rho_f(s)) : (r + rho_f(s));
      return v & mask;
   endfunction

   // One closure level: the peer map is an involution inside [0, p), so
   // target bit j picks up source bit peer(j).
   function automatic bitmap_type permute_f(input bitmap_type set, input step_type s,
                                            input rank_type mask);
      bitmap_type o;
      rank_type   jr;
      o = '0;
      for (int j = 0; j < RANKS; j++) begin
         jr = rank_type'(j);
         if ((jr & ~mask) == '0) begin
            o[j] = set[peer_f(jr, s, mask)];
         end
      end
      return o;
   endfunction

endpackage

// ===== rtl/swp_if.sv =====
// Valid/ready channel interfaces for swing_peer_bitmap.
// Depends on swp_pkg.
interface swp_req_if;
   logic              valid;
   logic              ready;
   swp_pkg::rank_type rank;
   swp_pkg::step_type step;

   modport source (output valid, output rank, output step, input ready);
   modport sink   (input valid, input rank, input step, output ready);
endinterface

interface swp_rsp_if;
   logic                valid;
   logic                ready;
   swp_pkg::rank_type   dest;
   swp_pkg::bitmap_type send_peers;
   swp_pkg::bitmap_type recv_peers;

   modport source (output valid, output dest, output send_peers, output recv_peers,
                   input ready);
   modport sink   (input valid, input dest, input send_peers, input recv_peers,
                   output ready);
endinterface

// ===== rtl/swp_closure.sv =====
// Peer closure over the steps after a given one: one permute level per step.
// Depends on swp_pkg.
module swp_closure (
   input  swp_pkg::rank_type   start,
   input  swp_pkg::step_type   step,
   input  swp_pkg::step_type   n_steps,
   input  swp_pkg::rank_type   mask,
   output swp_pkg::bitmap_type peers
);

   swp_pkg::bitmap_type lvl_set [swp_pkg::STEP_MAX];

   // level 0: the first peer, or nothing when step is past the schedule
   always_comb begin
      lvl_set[0] = '0;
      if (step < n_steps) begin
         lvl_set[0][swp_pkg::peer_f(start, step, mask)] = 1'b1;
      end
   end

   for (genvar lv = 1; lv < swp_pkg::STEP_MAX; lv++) begin : g_lvl
      localparam swp_pkg::step_type LvStep = swp_pkg::step_type'(lv);
      always_comb begin
         if (LvStep > step && LvStep < n_steps) begin
            lvl_set[lv] = lvl_set[lv-1] | swp_pkg::permute_f(lvl_set[lv-1], LvStep, mask);
         end else begin
            lvl_set[lv] = lvl_set[lv-1];
         end
      end
   end

   assign peers = lvl_set[swp_pkg::STEP_MAX-1];

endmodule

// ===== rtl/swing_peer_bitmap.sv =====
// Top level of the Swing allreduce peer schedule block.
// Depends on swp_pkg, swp_if.sv (swp_req_if, swp_rsp_if) and swp_closure.
//
//  channel | dir | word fields                         | handshake
//  --------+-----+-------------------------------------+-------------------
//  req     | in  | rank[5:0], step[2:0]                | valid/ready
//  rsp     | out | dest[5:0], send_peers, recv_peers   | valid/ready
//  csr     | in  | csr_wr_data[2:0] -> step_count      | csr_wr_en, no read
//
// One word per cycle sustained while rsp is ready. A word passes an input
// register, then the peer and both closures (up to five permute levels) into the
// result register. Reset is synchronous; step_count returns to 2 and both
// pipeline stages empty. A stalled rsp holds its word while req still fills
// the input stage, so one extra word is absorbed before req.ready drops.
module swing_peer_bitmap (
   input  logic                clock,
   input  logic                reset,
   swp_req_if.sink             req,
   swp_rsp_if.source           rsp,
   input  logic                csr_wr_en,
   input  swp_pkg::step_type   csr_wr_data
);

   // config register
   swp_pkg::step_type step_count_ff;

   // input stage
   logic              s1_valid_ff, s1_valid_in;
   swp_pkg::rank_type s1_rank_ff;
   swp_pkg::step_type s1_step_ff;

   // result stage
   logic                rsp_valid_ff, rsp_valid_in;
   swp_pkg::rank_type   dest_ff;
   swp_pkg::bitmap_type send_ff;
   swp_pkg::bitmap_type recv_ff;

   // datapath
   swp_pkg::step_type   n_steps;
   swp_pkg::rank_type   mask;
   swp_pkg::rank_type   dest_in;
   swp_pkg::bitmap_type send_in;
   swp_pkg::bitmap_type recv_in;
   logic                advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= swp_pkg::STEP_COUNT_RESET;
      end else if (csr_wr_en) begin
         step_count_ff <= csr_wr_data;
      end
   end

   // result register frees when empty or taken this cycle
   assign advance      = !rsp_valid_ff || rsp.ready;
   assign req.ready    = !s1_valid_ff || advance;
   assign s1_valid_in  = req.ready ? req.valid : s1_valid_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_rank_ff <= req.rank;
         s1_step_ff <= req.step;
      end
   end

   // p = 2^n; step_count above log2(RANKS) saturates
   assign n_steps = swp_pkg::eff_steps_f(step_count_ff);
   assign mask    = swp_pkg::mask_f(n_steps);
   assign dest_in = swp_pkg::peer_f(s1_rank_ff, s1_step_ff, mask);

   // send: closure from the rank; recv: closure from its peer
   swp_closure u_send (
      .start   (s1_rank_ff),
      .step    (s1_step_ff),
      .n_steps (n_steps),
      .mask    (mask),
      .peers   (send_in)
   );

   swp_closure u_recv (
      .start   (dest_in),
      .step    (s1_step_ff),
      .n_steps (n_steps),
      .mask    (mask),
      .peers   (recv_in)
   );

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         dest_ff <= dest_in;
         send_ff <= send_in;
         recv_ff <= recv_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.dest       = dest_ff;
   assign rsp.send_peers = send_ff;
   assign rsp.recv_peers = recv_ff;

endmodule

// ===== rtl/swp_checker.sv =====
// Port-level checks for swing_peer_bitmap, bound to the top level.
// Depends on swp_pkg and swing_peer_bitmap_macros.svh.
`include "swing_peer_bitmap_macros.svh"

module swp_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input swp_pkg::rank_type   rsp_dest,
   input swp_pkg::bitmap_type rsp_send_peers,
   input swp_pkg::bitmap_type rsp_recv_peers
);

   // whole rsp word, and whether each set has anything in it
   logic [swp_pkg::RANK_W+2*swp_pkg::RANKS-1:0] rsp_word;
   logic                                        send_any;
   logic                                        recv_any;

   assign rsp_word = {rsp_dest, rsp_send_peers, rsp_recv_peers};
   assign send_any = |rsp_send_peers;
   assign recv_any = |rsp_recv_peers;

   // a stalled word stays up and unchanged
   `SWP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SWP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_word))

   // an empty output side never blocks the input
   `SWP_ASSERT_IMPLY(a_req_free, clock, reset, !rsp_valid, req_ready)

   // a non-empty send set always starts at the peer
   `SWP_ASSERT_IMPLY(a_send_has_dest, clock, reset, rsp_valid && send_any, rsp_send_peers[rsp_dest])

   // both sets are empty together
   `SWP_ASSERT_IMPLY(a_sets_agree, clock, reset, rsp_valid, send_any == recv_any)

endmodule

bind swing_peer_bitmap swp_checker u_swp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_dest       (rsp.dest),
   .rsp_send_peers (rsp.send_peers),
   .rsp_recv_peers (rsp.recv_peers)
);
